[rtl/core/ipv4rx_pkg.sv]
package ipv4rx_pkg;

  localparam int unsigned MinHdrBytes = 20;
  localparam logic [7:0]  ProtoIcmp   = 8'd1;
  localparam logic [7:0]  ProtoUdp    = 8'd17;
  localparam logic [15:0] SumAllOnes  = 16'hffff;
  localparam logic [15:0] CountMax    = 16'hffff;
  localparam logic [3:0]  McastNibble = 4'he;

  typedef enum logic [2:0] {
    VERD_ACCEPT   = 3'd0,
    VERD_SHORT    = 3'd1,
    VERD_BAD_LEN  = 3'd2,
    VERD_BAD_CSUM = 3'd3,
    VERD_NOT_OURS = 3'd4
  } verdict_e;

  typedef enum logic [1:0] {
    CLASS_ICMP    = 2'd0,
    CLASS_UDP     = 2'd1,
    CLASS_UNKNOWN = 2'd2
  } upper_class_e;

  typedef enum logic [1:0] {
    REG_LOCAL_ADDR  = 2'd0,
    REG_ICMP_ENABLE = 2'd1,
    REG_UDP_ENABLE  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    verdict_e     verdict;
    upper_class_e upper_class;
    logic [5:0]   header_bytes;
    logic [15:0]  total_length;
    logic [31:0]  source_addr;
    logic         learn_source;
  } out_item_t;

  // Header summary of one finished packet, handed from front to back.
  typedef struct packed {
    logic [15:0] received;
    logic [5:0]  ihl_bytes;
    logic [15:0] sum;
    logic [15:0] length;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
  } pkt_sum_t;

  typedef struct packed {
    logic [31:0] local_addr;
    logic        icmp_enable;
    logic        udp_enable;
  } cfg_t;

endpackage

[rtl/core/ipv4rx_front.sv]
module ipv4rx_front
  import ipv4rx_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     push_o,
  output pkt_sum_t sum_o
);

  logic [15:0] cnt_q, cnt_d, cnt_next;
  logic [5:0]  ihl_q, ihl_d, ihl_now;
  logic [16:0] sum_q, sum_d, sum_next;
  logic [7:0]  high_q, high_d, high_next;
  logic [15:0] len_q, len_d, len_next;
  logic [7:0]  proto_q, proto_d, proto_next;
  logic [31:0] src_q, src_d, src_next;
  logic [31:0] dst_q, dst_d, dst_next;
  logic [17:0] raw_sum;
  logic [16:0] fold_sum;
  logic        in_hdr;
  logic [7:0]  b;

  assign b        = item_i.data_byte;
  assign ihl_now  = (cnt_q == 16'd0) ? {b[3:0], 2'b00} : ihl_q;
  assign in_hdr   = cnt_q < {10'd0, ihl_now};
  assign raw_sum  = {1'b0, sum_q} + {2'b00, high_q, b};
  assign fold_sum = {1'b0, raw_sum[15:0]} + {15'd0, raw_sum[17:16]};

  always_comb begin
    sum_next   = sum_q;
    high_next  = high_q;
    len_next   = len_q;
    proto_next = proto_q;
    src_next   = src_q;
    dst_next   = dst_q;
    // Odd header positions close a 16-bit word, even ones open it.
    if (in_hdr) begin
      if (cnt_q[0]) begin
        sum_next = fold_sum;
      end else begin
        high_next = b;
      end
    end
    if (cnt_q == 16'd2) begin
      len_next = {b, len_q[7:0]};
    end
    if (cnt_q == 16'd3) begin
      len_next = {len_q[15:8], b};
    end
    if (cnt_q == 16'd9) begin
      proto_next = b;
    end
    if (cnt_q >= 16'd12 && cnt_q < 16'd16) begin
      src_next = {src_q[23:0], b};
    end
    if (cnt_q >= 16'd16 && cnt_q < 16'd20) begin
      dst_next = {dst_q[23:0], b};
    end
    cnt_next = (cnt_q == CountMax) ? cnt_q : cnt_q + 16'd1;
  end

  always_comb begin
    cnt_d   = cnt_q;
    ihl_d   = ihl_q;
    sum_d   = sum_q;
    high_d  = high_q;
    len_d   = len_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    if (accept_i) begin
      if (item_i.last_byte) begin
        // Clear per-packet state once the summary is queued.
        cnt_d   = '0;
        ihl_d   = '0;
        sum_d   = '0;
        high_d  = '0;
        len_d   = '0;
        proto_d = '0;
        src_d   = '0;
        dst_d   = '0;
      end else begin
        cnt_d   = cnt_next;
        ihl_d   = ihl_now;
        sum_d   = sum_next;
        high_d  = high_next;
        len_d   = len_next;
        proto_d = proto_next;
        src_d   = src_next;
        dst_d   = dst_next;
      end
    end
  end

  assign push_o = accept_i && item_i.last_byte;

  always_comb begin
    sum_o.received  = cnt_next;
    sum_o.ihl_bytes = ihl_now;
    sum_o.sum       = sum_next[15:0];
    sum_o.length    = len_next;
    sum_o.proto     = proto_next;
    sum_o.src       = src_next;
    sum_o.dst       = dst_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ihl_q   <= '0;
      sum_q   <= '0;
      high_q  <= '0;
      len_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
    end else begin
      cnt_q   <= cnt_d;
      ihl_q   <= ihl_d;
      sum_q   <= sum_d;
      high_q  <= high_d;
      len_q   <= len_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
    end
  end

endmodule

[rtl/core/ipv4rx_queue.sv]
module ipv4rx_queue
  import ipv4rx_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pkt_sum_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output pkt_sum_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pkt_sum_t            store_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[rtl/core/ipv4rx_back.sv]
module ipv4rx_back
  import ipv4rx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      sum_valid_i,
  input  pkt_sum_t  sum_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, result;
  verdict_e  verdict;

  always_comb begin
    if (sum_i.received < 16'(MinHdrBytes)) begin
      verdict = VERD_SHORT;
    end else if (sum_i.length <= {10'd0, sum_i.ihl_bytes} ||
                 sum_i.received < sum_i.length) begin
      verdict = VERD_BAD_LEN;
    end else if (sum_i.sum != SumAllOnes) begin
      verdict = VERD_BAD_CSUM;
    end else if (sum_i.dst != cfg_i.local_addr && sum_i.dst[31:28] != McastNibble) begin
      verdict = VERD_NOT_OURS;
    end else begin
      verdict = VERD_ACCEPT;
    end
  end

  always_comb begin
    result.verdict      = verdict;
    result.upper_class  = CLASS_UNKNOWN;
    result.header_bytes = sum_i.ihl_bytes;
    result.total_length = sum_i.length;
    result.source_addr  = sum_i.src;
    result.learn_source = 1'b0;
    if (verdict == VERD_ACCEPT) begin
      result.learn_source = sum_i.src != '0;
      if (sum_i.proto == ProtoIcmp && cfg_i.icmp_enable) begin
        result.upper_class = CLASS_ICMP;
      end else if (sum_i.proto == ProtoUdp && cfg_i.udp_enable) begin
        result.upper_class = CLASS_UDP;
      end
    end
  end

  // Load the output register whenever it is empty or being drained.
  assign pop_o       = sum_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_d = pop_o || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/core/ipv4_receive_header_check_unit.sv]
// IPv4 receive header check. Feed a received packet one byte per transfer on
// the input channel, header first, with last_byte set on the final byte; one
// verdict comes out per packet, none for the other bytes. While the queue has
// room the front end takes one byte every cycle: it folds the ones' complement
// header checksum over 4*IHL bytes and captures total length, protocol and
// both addresses, so a byte's work is one 16-bit add with an end-around carry
// plus field capture. On the last byte the front pushes a header summary into
// a small queue (QueueDepth entries); the back end pops it, runs the checks in
// order (too short, bad length, bad checksum, not for us) and classes accepted
// packets as ICMP, UDP or unknown. Results sit in an output register, so a
// stalled consumer only stops input once the queue and that register are
// full; the input channel holds off only then. When nothing is stalled the
// verdict goes from the last byte's transfer into the queue and then into the
// output register. The received byte count saturates at 65535. Configuration
// registers sit on the APB port at byte offsets 0x0 (local_addr), 0x4
// (icmp_enable, bit 0) and 0x8 (udp_enable, bit 0); write them only while no
// packet is in flight. Reads return the current values, pready is tied
// high.
module ipv4_receive_header_check_unit
  import ipv4rx_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg_q, cfg_d;
  logic     cfg_write;
  reg_idx_e reg_idx;
  logic     queue_full, in_accept, push, pop, sum_valid;
  pkt_sum_t front_sum, back_sum;

  // Register file: write on the APB access phase.
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      unique case (reg_idx)
        REG_LOCAL_ADDR:  cfg_d.local_addr  = pwdata;
        REG_ICMP_ENABLE: cfg_d.icmp_enable = pwdata[0];
        REG_UDP_ENABLE:  cfg_d.udp_enable  = pwdata[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOCAL_ADDR:  prdata = cfg_q.local_addr;
      REG_ICMP_ENABLE: prdata = {31'd0, cfg_q.icmp_enable};
      REG_UDP_ENABLE:  prdata = {31'd0, cfg_q.udp_enable};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_addr  <= '0;
      cfg_q.icmp_enable <= 1'b1;
      cfg_q.udp_enable  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Hold off input only while the summary queue has no room.
  assign in_ready_o = !queue_full;
  assign in_accept  = in_valid_i && in_ready_o;

  ipv4rx_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .push_o   (push),
    .sum_o    (front_sum)
  );

  ipv4rx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_sum),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (sum_valid),
    .data_o  (back_sum)
  );

  ipv4rx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .sum_valid_i (sum_valid),
    .sum_i       (back_sum),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/core/ipv4rx_checker.sv]
module ipv4rx_checker
  import ipv4rx_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_item_t   out_data_o
);

  // A stalled result keeps its valid and its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Only an accepted packet may ask to learn its source.
  a_learn_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.learn_source |-> out_data_o.verdict == VERD_ACCEPT)
    else $error("learn flag on rejected packet");

  // A rejected packet is never delivered to an upper layer.
  a_reject_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.verdict != VERD_ACCEPT |->
      out_data_o.upper_class == CLASS_UNKNOWN)
    else $error("rejected packet classed for delivery");

  // Header length always comes from IHL, so it is a multiple of four.
  a_hdr_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.header_bytes[1:0] == 2'b00)
    else $error("header length not a whole number of words");

endmodule

bind ipv4_receive_header_check_unit ipv4rx_checker u_checker (.*);
